### design/csq_pkg.sv
// shared constants, types and codes for the counted sorted queue
// no dependencies; used by csq_cell and counted_sorted_queue
package csq_pkg;

    localparam int ENTRIES    = 16;
    localparam int KEY_BITS   = 64;
    localparam int COUNT_BITS = 16;
    localparam int USED_W     = $clog2(ENTRIES + 1);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [2:0] {
        STATUS_NEW     = 3'd0,
        STATUS_INC     = 3'd1,
        STATUS_DEC     = 3'd2,
        STATUS_REMOVED = 3'd3,
        STATUS_EMPTY   = 3'd4,
        STATUS_FULL    = 3'd5,
        STATUS_SAT     = 3'd6
    } status_t;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_SERVE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] count;
    } entry_t;

    // per-cell command, one pulse per phase
    typedef struct packed {
        logic cmp;   // compare broadcast key against held entry
        logic inc;   // matching cell bumps its count
        logic ins;   // open a slot and place the broadcast key
        logic dec;   // head cell lowers its count
        logic pop;   // every cell takes its right neighbor
    } cell_cmd_t;

endpackage

### design/csq_cell.sv
// one cell of the sorted chain: holds one entry and its compare flags
// depends on csq_pkg
module csq_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  csq_pkg::cell_cmd_t              cmd,
    input  logic [csq_pkg::KEY_BITS-1:0]    key_in,
    input  csq_pkg::entry_t                 left_ent,
    input  logic                            left_lt,
    input  csq_pkg::entry_t                 right_ent,
    output csq_pkg::entry_t                 ent,
    output logic                            lt,
    output logic                            eq
);

    logic                               valid_reg, valid_next;
    logic [csq_pkg::KEY_BITS-1:0]       key_reg, key_next;
    logic [csq_pkg::COUNT_BITS-1:0]     count_reg, count_next;
    logic                               lt_reg, lt_next;
    logic                               eq_reg, eq_next;

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        count_next = count_reg;
        lt_next    = lt_reg;
        eq_next    = eq_reg;
        if (cmd.cmp)
        begin
            // an empty cell counts as holding a larger key
            lt_next = !valid_reg || (key_in < key_reg);
            eq_next = valid_reg && (key_in == key_reg);
        end
        if (cmd.inc && eq_reg)
        begin
            if (count_reg != csq_pkg::COUNT_MAX)
                count_next = count_reg + csq_pkg::COUNT_BITS'(1);
        end
        if (cmd.ins && lt_reg)
        begin
            if (left_lt)
            begin
                valid_next = left_ent.valid;
                key_next   = left_ent.key;
                count_next = left_ent.count;
            end
            else
            begin
                valid_next = 1'b1;
                key_next   = key_in;
                count_next = csq_pkg::COUNT_BITS'(1);
            end
        end
        if (cmd.dec)
            count_next = count_reg - csq_pkg::COUNT_BITS'(1);
        if (cmd.pop)
        begin
            valid_next = right_ent.valid;
            key_next   = right_ent.key;
            count_next = right_ent.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        count_reg <= count_next;
    end

    assign ent.valid = valid_reg;
    assign ent.key   = key_reg;
    assign ent.count = count_reg;
    assign lt        = lt_reg;
    assign eq        = eq_reg;

endmodule

### design/counted_sorted_queue.sv
// top level of the counted sorted queue: control, result register, cell chain
// depends on csq_pkg and csq_cell
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid, in_ready, opcode, key           | insert key or serve min
//  out     | out_valid, out_ready, status, result_key, | one result item per
//          | result_count, entries_used                | input item
//
// an item passes through the accepting idle state, a compare state in which every cell
// tests the broadcast key, and an update state that shifts the chain and loads the
// result register; out_valid rises once the update state goes ahead
// reset clears valid bits, fill count, control state and the output valid flag
// a result waiting on out_ready holds the update phase; input is taken only
// when the control is idle, while an earlier result may still be waiting
module counted_sorted_queue (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             opcode,
    input  logic [csq_pkg::KEY_BITS-1:0]     key,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       status,
    output logic [csq_pkg::KEY_BITS-1:0]     result_key,
    output logic [csq_pkg::COUNT_BITS-1:0]   result_count,
    output logic [csq_pkg::USED_W-1:0]       entries_used
);

    csq_pkg::state_t                  state_reg, state_next;

    // captured item
    logic                             op_reg;
    logic [csq_pkg::KEY_BITS-1:0]     key_reg;

    // distinct keys held
    logic [csq_pkg::USED_W-1:0]       used_reg, used_next;

    // result register
    logic                             out_valid_reg;
    csq_pkg::status_t                 status_reg, status_next;
    logic [csq_pkg::KEY_BITS-1:0]     rkey_reg, rkey_next;
    logic [csq_pkg::COUNT_BITS-1:0]   rcount_reg, rcount_next;
    logic [csq_pkg::USED_W-1:0]       rused_reg;

    // cell chain
    csq_pkg::entry_t                  ent [csq_pkg::ENTRIES];
    logic                             lt  [csq_pkg::ENTRIES];
    logic                             eq  [csq_pkg::ENTRIES];
    csq_pkg::cell_cmd_t               cmd_head, cmd_body;

    logic                             accept;
    logic                             upd_go;
    logic                             any_eq;
    logic [csq_pkg::COUNT_BITS-1:0]   hit_count;
    logic                             full;
    logic                             empty;
    logic                             head_last;

    assign accept    = in_valid && in_ready;
    assign upd_go    = (state_reg == csq_pkg::S_UPD) && (!out_valid_reg || out_ready);
    assign full      = (used_reg == csq_pkg::USED_W'(csq_pkg::ENTRIES));
    assign empty     = (used_reg == '0);
    assign head_last = (ent[0].count == csq_pkg::COUNT_BITS'(1));

    // matching cell is one-hot, so an or over masked counts picks it out
    always_comb
    begin
        any_eq    = 1'b0;
        hit_count = '0;
        for (int i = 0; i < csq_pkg::ENTRIES; i++)
        begin
            any_eq    = any_eq | eq[i];
            hit_count = hit_count | (eq[i] ? ent[i].count : '0);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csq_pkg::S_IDLE: if (accept) state_next = csq_pkg::S_CMP;
            csq_pkg::S_CMP:  state_next = csq_pkg::S_UPD;
            csq_pkg::S_UPD:  if (upd_go) state_next = csq_pkg::S_IDLE;
            default:         state_next = csq_pkg::S_IDLE;
        endcase
    end

    // phase outputs
    always_comb
    begin
        in_ready = 1'b0;
        cmd_body = '0;
        unique case (state_reg)
            csq_pkg::S_IDLE: in_ready = 1'b1;
            csq_pkg::S_CMP:  cmd_body.cmp = (op_reg == csq_pkg::OP_INSERT);
            csq_pkg::S_UPD:
            begin
                if (upd_go)
                begin
                    if (op_reg == csq_pkg::OP_INSERT)
                    begin
                        cmd_body.inc = any_eq;
                        cmd_body.ins = !any_eq && !full;
                    end
                    else
                    begin
                        cmd_body.pop = !empty && head_last;
                    end
                end
            end
            default: in_ready = 1'b0;
        endcase
    end

    // only the head cell decrements
    always_comb
    begin
        cmd_head     = cmd_body;
        cmd_head.dec = upd_go && (op_reg == csq_pkg::OP_SERVE) && !empty && !head_last;
    end

    // result and fill count
    always_comb
    begin
        used_next   = used_reg;
        status_next = csq_pkg::STATUS_EMPTY;
        rkey_next   = key_reg;
        rcount_next = '0;
        if (op_reg == csq_pkg::OP_INSERT)
        begin
            if (any_eq)
            begin
                if (hit_count == csq_pkg::COUNT_MAX)
                begin
                    status_next = csq_pkg::STATUS_SAT;
                    rcount_next = csq_pkg::COUNT_MAX;
                end
                else
                begin
                    status_next = csq_pkg::STATUS_INC;
                    rcount_next = hit_count + csq_pkg::COUNT_BITS'(1);
                end
            end
            else if (full)
            begin
                status_next = csq_pkg::STATUS_FULL;
            end
            else
            begin
                status_next = csq_pkg::STATUS_NEW;
                rcount_next = csq_pkg::COUNT_BITS'(1);
                used_next   = used_reg + csq_pkg::USED_W'(1);
            end
        end
        else
        begin
            if (empty)
            begin
                status_next = csq_pkg::STATUS_EMPTY;
                rkey_next   = '0;
            end
            else if (head_last)
            begin
                status_next = csq_pkg::STATUS_REMOVED;
                rkey_next   = ent[0].key;
                used_next   = used_reg - csq_pkg::USED_W'(1);
            end
            else
            begin
                status_next = csq_pkg::STATUS_DEC;
                rkey_next   = ent[0].key;
                rcount_next = ent[0].count - csq_pkg::COUNT_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= csq_pkg::S_IDLE;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_go)
            begin
                used_reg      <= used_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= opcode;
            key_reg <= key;
        end
        if (upd_go)
        begin
            status_reg <= status_next;
            rkey_reg   <= rkey_next;
            rcount_reg <= rcount_next;
            rused_reg  <= used_next;
        end
    end

    // chain of cells, ascending keys from cell 0
    for (genvar i = 0; i < csq_pkg::ENTRIES; i++)
    begin : g_cell
        csq_pkg::entry_t left_ent, right_ent;
        logic            left_lt;
        if (i == 0)
        begin : g_first
            assign left_ent = '0;
            assign left_lt  = 1'b0;
        end
        else
        begin : g_inner
            assign left_ent = ent[i-1];
            assign left_lt  = lt[i-1];
        end
        if (i == csq_pkg::ENTRIES - 1)
        begin : g_last
            assign right_ent = '0;
        end
        else
        begin : g_mid
            assign right_ent = ent[i+1];
        end

        csq_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       ((i == 0) ? cmd_head : cmd_body),
            .key_in    (key_reg),
            .left_ent  (left_ent),
            .left_lt   (left_lt),
            .right_ent (right_ent),
            .ent       (ent[i]),
            .lt        (lt[i]),
            .eq        (eq[i])
        );
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_key   = rkey_reg;
    assign result_count = rcount_reg;
    assign entries_used = rused_reg;

endmodule
